### hdl/csrc_pkg.sv
package csrc_pkg;

	// Fixed field widths of the entry payload.
	localparam int ROW_WIDTH   = 10;
	localparam int COL_WIDTH   = 10;
	localparam int VALUE_WIDTH = 64;
	localparam int CNT_WIDTH   = 11;

	// Command codes of the action field.
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_FETCH = 1'b1;

	// Result kinds.
	localparam logic KIND_PTR   = 1'b0;
	localparam logic KIND_ENTRY = 1'b1;

	typedef struct packed {
		logic                   action;
		logic [ROW_WIDTH-1:0]   entry_row;
		logic [COL_WIDTH-1:0]   entry_col;
		logic [VALUE_WIDTH-1:0] entry_value;
		logic                   entry_last;
	} in_t;

	typedef struct packed {
		logic                   valid_res;
		logic                   kind;
		logic [CNT_WIDTH-1:0]   position;
		logic [CNT_WIDTH-1:0]   row_pointer;
		logic [ROW_WIDTH-1:0]   out_row;
		logic [COL_WIDTH-1:0]   out_col;
		logic [VALUE_WIDTH-1:0] out_value;
		logic                   readout_last;
		logic                   overflow;
	} out_t;

	// One stored matrix entry.
	typedef struct packed {
		logic [ROW_WIDTH-1:0]   row;
		logic [COL_WIDTH-1:0]   col;
		logic [VALUE_WIDTH-1:0] value;
	} entry_t;

endpackage

### hdl/coo_sort_to_csr_converter.sv
// COO to CSR converter.
// A command beat is taken when start is high and busy is low. A load beat
// (action 0) stores one entry (row, column, value); a load marked last ends
// the matrix, after which the row pointers are built. A fetch beat (action 1)
// returns exactly one result beat on result, marked by result_strobe for one
// cycle, in the cycle after the fetch was taken. The receiver cannot stall it.
// Readout order: row pointers 0..row_count, row_count clamped to 1..MAX_ROWS,
// then the entries sorted by row, then column, equal keys in arrival order.
// Loads are sorted on arrival by insertion into the entry memory. A load into
// an empty matrix is written directly and a dropped load is discarded; any
// other load shifts each stored entry with a larger key up by one slot, one
// memory shift per cycle. The last load then starts the pointer sweep, one
// pointer write or entry step per cycle. Fetches are taken every cycle while
// busy is low, each a single read of the pointer or entry memory. Loads past
// MAX_ENTRIES are dropped and flagged in overflow.
// After reset the block is idle and loading an empty matrix, row_count is
// 1024, and memory contents are undefined until written.
module coo_sort_to_csr_converter
	import csrc_pkg::*;
#(
	parameter int MAX_ENTRIES = 1024,
	parameter int MAX_ROWS    = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  in_t                  cmd,
	input  logic                 cfg_we,
	input  logic [CNT_WIDTH-1:0] cfg_data,
	output logic                 result_strobe,
	output out_t                 result
);

	localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int PW  = $clog2(MAX_ROWS + 1);
	localparam int RCW = $clog2(MAX_ROWS + 2);
	localparam int KW  = $clog2(MAX_ROWS + MAX_ENTRIES + 2);

	typedef enum logic [2:0] {ST_IDLE, ST_CMP, ST_PUT, ST_PREP, ST_BUILD} state_t;
	typedef enum logic [1:0] {PH_LOAD, PH_READOUT, PH_DONE} phase_t;

	state_t               state_q;
	phase_t               phase_q;
	logic [CW-1:0]        total_q;
	logic [CW-1:0]        j_q;
	logic [RCW-1:0]       r_q;
	logic [KW-1:0]        k_q;
	logic                 dropped_q;
	logic                 last_q;
	logic [CNT_WIDTH-1:0] row_count_q;
	entry_t               new_q;

	// Memories and their registered read data.
	entry_t               ent_mem [MAX_ENTRIES];
	logic [CW-1:0]        ptr_mem [MAX_ROWS+1];
	entry_t               ent_rd_q;
	logic [CW-1:0]        ptr_rd_q;

	// Fetch result metadata, aligned with the read data.
	logic                 strobe_s1;
	logic                 valid_s1;
	logic                 kind_s1;
	logic [CNT_WIDTH-1:0] pos_s1;
	logic                 last_s1;
	logic                 ovf_s1;

	logic                 ent_we;
	logic [EW-1:0]        ent_waddr;
	entry_t               ent_wdata;
	logic [EW-1:0]        ent_raddr;
	logic                 ptr_we;
	logic [PW-1:0]        ptr_waddr;
	logic [PW-1:0]        ptr_raddr;

	logic                 take;
	logic                 is_load;
	logic                 is_fetch;
	logic [CW-1:0]        tot_eff;
	logic [RCW-1:0]       rc_c;
	logic [RCW-1:0]       npt_c;
	logic [KW-1:0]        sum_c;
	logic [KW-1:0]        eidx_c;
	logic                 greater;
	logic                 adv;
	entry_t               load_ent;

	assign busy     = (state_q != ST_IDLE);
	assign take     = start && !busy;
	assign is_load  = take && (cmd.action == ACT_LOAD);
	assign is_fetch = take && (cmd.action == ACT_FETCH);
	assign tot_eff  = (phase_q != PH_LOAD) ? '0 : total_q;
	assign load_ent = '{row: cmd.entry_row, col: cmd.entry_col, value: cmd.entry_value};

	// Rows in use, clamped to 1..MAX_ROWS, and readout length.
	always_comb begin
		if (row_count_q == '0) begin
			rc_c = RCW'(1);
		end else if (int'(row_count_q) > MAX_ROWS) begin
			rc_c = RCW'(MAX_ROWS);
		end else begin
			rc_c = RCW'(row_count_q);
		end
	end
	assign npt_c  = rc_c + RCW'(1);
	assign sum_c  = KW'(npt_c) + KW'(total_q);
	assign eidx_c = k_q - KW'(npt_c);

	// Key order of the stored entry against the one being inserted.
	assign greater = (ent_rd_q.row > new_q.row) ||
		((ent_rd_q.row == new_q.row) && (ent_rd_q.col > new_q.col));
	// Pointer sweep steps past entries whose row lies below the current row.
	assign adv = (j_q < total_q) && (32'(ent_rd_q.row) < 32'(r_q));

	// Memory port selection.
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = j_q[EW-1:0];
		ent_wdata = new_q;
		ent_raddr = eidx_c[EW-1:0];
		ptr_we    = 1'b0;
		ptr_waddr = r_q[PW-1:0];
		ptr_raddr = k_q[PW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (is_load && (tot_eff == '0)) begin
					ent_we    = 1'b1;
					ent_waddr = '0;
					ent_wdata = load_ent;
				end
				if (is_load) begin
					ent_raddr = EW'(tot_eff - CW'(1));
				end
			end
			ST_CMP: begin
				ent_we    = 1'b1;
				ent_wdata = greater ? ent_rd_q : new_q;
				ent_raddr = EW'(j_q - CW'(2));
			end
			ST_PUT: begin
				ent_we = 1'b1;
			end
			ST_PREP: begin
				ent_raddr = '0;
			end
			ST_BUILD: begin
				ptr_we    = !adv;
				ent_raddr = adv ? EW'(j_q + CW'(1)) : j_q[EW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Entry memory.
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		ent_rd_q <= ent_mem[ent_raddr];
	end

	// Row pointer memory.
	always_ff @(posedge clk) begin
		if (ptr_we) begin
			ptr_mem[ptr_waddr] <= j_q;
		end
		ptr_rd_q <= ptr_mem[ptr_raddr];
	end

	// Control state machine and fetch pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_LOAD;
			total_q     <= '0;
			j_q         <= '0;
			r_q         <= '0;
			k_q         <= '0;
			dropped_q   <= 1'b0;
			last_q      <= 1'b0;
			row_count_q <= CNT_WIDTH'(1024);
			strobe_s1   <= 1'b0;
			valid_s1    <= 1'b0;
			kind_s1     <= KIND_PTR;
			pos_s1      <= '0;
			last_s1     <= 1'b0;
			ovf_s1      <= 1'b0;
			new_q       <= '0;
		end else begin
			if (cfg_we) begin
				row_count_q <= cfg_data;
			end
			strobe_s1 <= is_fetch;
			unique case (state_q)
				ST_IDLE: begin
					if (is_load) begin
						new_q  <= load_ent;
						last_q <= cmd.entry_last;
						if (phase_q != PH_LOAD) begin
							phase_q   <= PH_LOAD;
							dropped_q <= 1'b0;
							k_q       <= '0;
						end
						if (int'(tot_eff) < MAX_ENTRIES) begin
							if (tot_eff == '0) begin
								total_q <= CW'(1);
								if (cmd.entry_last) begin
									state_q <= ST_PREP;
								end
							end else begin
								j_q     <= tot_eff;
								state_q <= ST_CMP;
							end
						end else begin
							dropped_q <= 1'b1;
							if (cmd.entry_last) begin
								state_q <= ST_PREP;
							end
						end
					end else if (is_fetch) begin
						ovf_s1   <= dropped_q;
						valid_s1 <= 1'b0;
						kind_s1  <= KIND_PTR;
						pos_s1   <= '0;
						last_s1  <= 1'b0;
						if (phase_q == PH_READOUT) begin
							if (k_q < sum_c) begin
								valid_s1 <= 1'b1;
								if (k_q < KW'(npt_c)) begin
									kind_s1 <= KIND_PTR;
									pos_s1  <= CNT_WIDTH'(k_q);
								end else begin
									kind_s1 <= KIND_ENTRY;
									pos_s1  <= CNT_WIDTH'(eidx_c);
								end
								last_s1 <= (k_q + KW'(1) == sum_c);
								k_q     <= k_q + KW'(1);
								if (k_q + KW'(1) >= sum_c) begin
									phase_q <= PH_DONE;
								end
							end else begin
								phase_q <= PH_DONE;
							end
						end
					end
				end
				ST_CMP: begin
					if (greater && (j_q > CW'(1))) begin
						j_q <= j_q - CW'(1);
					end else if (greater) begin
						j_q     <= '0;
						state_q <= ST_PUT;
					end else begin
						total_q <= total_q + CW'(1);
						state_q <= last_q ? ST_PREP : ST_IDLE;
					end
				end
				ST_PUT: begin
					total_q <= total_q + CW'(1);
					state_q <= last_q ? ST_PREP : ST_IDLE;
				end
				ST_PREP: begin
					j_q     <= '0;
					r_q     <= '0;
					state_q <= ST_BUILD;
				end
				ST_BUILD: begin
					if (adv) begin
						j_q <= j_q + CW'(1);
					end else if (int'(r_q) == MAX_ROWS) begin
						phase_q <= PH_READOUT;
						k_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						r_q <= r_q + RCW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result beat assembled from the read data.
	always_comb begin
		result              = '0;
		result.valid_res    = valid_s1;
		result.kind         = kind_s1;
		result.position     = pos_s1;
		result.readout_last = last_s1;
		result.overflow     = ovf_s1;
		if (valid_s1 && (kind_s1 == KIND_PTR)) begin
			result.row_pointer = CNT_WIDTH'(ptr_rd_q);
		end
		if (valid_s1 && (kind_s1 == KIND_ENTRY)) begin
			result.out_row   = ent_rd_q.row;
			result.out_col   = ent_rd_q.col;
			result.out_value = ent_rd_q.value;
		end
	end
	assign result_strobe = strobe_s1;

`ifndef SYNTHESIS
	// A result beat only follows a taken fetch beat.
	a_strobe_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(start && !busy && (cmd.action == ACT_FETCH)))
		else $error("result beat without a fetch");
	// The insertion compare always has a stored neighbor to look at.
	a_cmp_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (j_q != '0))
		else $error("insertion compare at index zero");
	// The entry count never exceeds capacity.
	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		int'(total_q) <= MAX_ENTRIES)
		else $error("entry count beyond capacity");
	// The pointer sweep never runs past the stored entries.
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUILD) |-> (j_q <= total_q))
		else $error("pointer sweep beyond entry count");
`endif

endmodule
